// ----- rtl/core/swrt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrt_pkg
// Shared constants and types of the sliding window request throttle.
// ----------------------------------------------------------------------------
package swrt_pkg;

    localparam int QUEUE_DEPTH   = 64;
    localparam int Q_FW          = $clog2(QUEUE_DEPTH + 1);
    localparam int LOG_DEPTH     = 1024;
    localparam int LOG_AW        = $clog2(LOG_DEPTH);
    localparam int LOG_FW        = $clog2(LOG_DEPTH + 1);
    localparam int MS_PER_SECOND = 1000;
    localparam int DIV_W         = 23;
    localparam int RATE_W        = 11;

    typedef enum logic [2:0] {
        CODE_SENT         = 3'd0,
        CODE_HEAD_TIMEOUT = 3'd1,
        CODE_DAILY        = 3'd2,
        CODE_TAIL_TIMEOUT = 3'd3,
        CODE_THROTTLED    = 3'd4,
        CODE_IDLE         = 3'd5,
        CODE_QUEUED       = 3'd6,
        CODE_REJECT       = 3'd7
    } t_code;

    typedef enum logic [1:0] {
        CFG_RATE_LIMIT  = 2'd0,
        CFG_DAILY_LIMIT = 2'd1,
        CFG_WINDOW_MS   = 2'd2,
        CFG_START_DAILY = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        Q_HOLD = 2'd0,
        Q_INS  = 2'd1,
        Q_POP  = 2'd2,
        Q_DROP = 2'd3
    } t_qop;

    typedef struct packed {
        logic [15:0] tag;
        logic [15:0] count;
        logic [47:0] key;
        logic [31:0] time_ms;
        logic [31:0] timeout;
    } t_req;

    typedef struct packed {
        t_qop op;
        t_req item;
    } t_qctl;

    typedef struct packed {
        logic        pop;
        logic        push;
        logic [31:0] wdata;
    } t_logctl;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH,
        S_POLL,
        S_EXP_RD,
        S_EXP_CHK,
        S_DECIDE,
        S_APPEND,
        S_DIV,
        S_MUL,
        S_FC,
        S_DONE
    } t_state;

endpackage

// ----- rtl/core/swrt_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrt_cell
// One slot of the sorted request queue; shifts with its neighbors.
// ----------------------------------------------------------------------------
module swrt_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  swrt_pkg::t_qctl i_ctl,
    input  swrt_pkg::t_req  i_left_data,
    input  logic            i_left_valid,
    input  logic            i_left_p,
    input  swrt_pkg::t_req  i_right_data,
    input  logic            i_right_valid,
    output swrt_pkg::t_req  o_data,
    output logic            o_valid,
    output logic            o_p
);

    swrt_pkg::t_req r_data;
    logic           r_valid;

    // slot at or after the insert point
    assign o_p     = !r_valid || (r_data.key < i_ctl.item.key);
    assign o_data  = r_data;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            swrt_pkg::Q_INS: begin
                if (o_p) begin
                    r_data <= i_left_p ? i_left_data : i_ctl.item;
                end
            end
            swrt_pkg::Q_POP: begin
                r_data <= i_right_data;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            case (i_ctl.op)
                swrt_pkg::Q_INS:  r_valid <= r_valid || i_left_valid;
                swrt_pkg::Q_POP:  r_valid <= i_right_valid;
                swrt_pkg::Q_DROP: r_valid <= r_valid && i_right_valid;
                default:          r_valid <= r_valid;
            endcase
        end
    end

endmodule

// ----- rtl/core/swrt_log.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrt_log
// Ring buffer of send times with a registered read of the oldest entry.
// ----------------------------------------------------------------------------
module swrt_log (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  swrt_pkg::t_logctl             i_ctl,
    output logic [swrt_pkg::LOG_FW-1:0]   o_fill,
    output logic [31:0]                   o_head_time
);

    logic [31:0]                 r_mem [swrt_pkg::LOG_DEPTH];
    logic [swrt_pkg::LOG_AW-1:0] r_head;
    logic [swrt_pkg::LOG_FW-1:0] r_fill;
    logic [31:0]                 r_rd;
    logic [swrt_pkg::LOG_AW-1:0] w_waddr;
    logic                        w_full;

    assign w_full  = (r_fill == swrt_pkg::LOG_FW'(swrt_pkg::LOG_DEPTH));
    assign w_waddr = r_head + r_fill[swrt_pkg::LOG_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[w_waddr] <= i_ctl.wdata;
        end
        r_rd <= r_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_fill <= '0;
        end else if (i_ctl.push) begin
            if (w_full) begin
                r_head <= r_head + 1'b1;
            end else begin
                r_fill <= r_fill + 1'b1;
            end
        end else if (i_ctl.pop) begin
            r_head <= r_head + 1'b1;
            r_fill <= r_fill - 1'b1;
        end
    end

    assign o_fill      = r_fill;
    assign o_head_time = r_rd;

endmodule

// ----- rtl/core/swrt_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrt_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module swrt_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [swrt_pkg::DIV_W-1:0]    i_dividend,
    input  logic [swrt_pkg::RATE_W-1:0]   i_divisor,
    output logic                          o_done,
    output logic [swrt_pkg::DIV_W-1:0]    o_quot
);

    localparam int CW = $clog2(swrt_pkg::DIV_W + 1);

    logic [swrt_pkg::DIV_W-1:0]  r_q;
    logic [swrt_pkg::RATE_W:0]   r_rem;
    logic [CW-1:0]               r_cnt;
    logic                        r_busy;
    logic                        r_done;
    logic [swrt_pkg::RATE_W:0]   w_sh;
    logic                        w_ge;

    assign w_sh = {r_rem[swrt_pkg::RATE_W-1:0], r_q[swrt_pkg::DIV_W-1]};
    assign w_ge = (w_sh >= {1'b0, i_divisor});

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_sh - {1'b0, i_divisor}) : w_sh;
            r_q   <= {r_q[swrt_pkg::DIV_W-2:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(swrt_pkg::DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ----- rtl/core/sliding_window_request_throttle_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_request_throttle_unit
// Sorted request queue with sliding window send log, daily cap and timeouts.
// ----------------------------------------------------------------------------
//  channel  handshake                    payload
//  in       i_in_valid / o_in_ready      i_func .. i_is_withdraw
//  out      o_out_valid / i_out_ready    o_code .. o_throttled
//  cfg      i_cfg_we                     i_cfg_idx, i_cfg_data
//
//  push: S_PUSH, then S_DONE. poll: S_POLL, then S_DONE on an empty queue,
//  else S_EXP_RD and S_EXP_CHK per expired log entry, S_DECIDE, one S_APPEND
//  per logged command on a send (up to 1024), and S_DIV (serial divider),
//  S_MUL and S_FC when the tail forecast is needed. A new transaction
//  is taken while a result waits at the output; the next result waits in
//  S_DONE. Reset is synchronous and empties queue and log at once.
module sliding_window_request_throttle_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_func,
    input  logic [31:0] i_time_ms,
    input  logic [15:0] i_msg_tag,
    input  logic [15:0] i_cmd_count,
    input  logic [47:0] i_sort_key,
    input  logic [31:0] i_timeout_ms,
    input  logic        i_is_withdraw,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_code,
    output logic [15:0] o_out_tag,
    output logic [15:0] o_out_count,
    output logic signed [32:0] o_delay_ms,
    output logic [31:0] o_daily_total,
    output logic [22:0] o_queued_total,
    output logic        o_throttled,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    localparam int QD = swrt_pkg::QUEUE_DEPTH;

    swrt_pkg::t_state r_state, n_state;

    swrt_pkg::t_req r_item;

    logic [10:0] r_rate;
    logic [31:0] r_dlim;
    logic [15:0] r_win;
    logic [swrt_pkg::Q_FW-1:0] r_fill, n_fill;
    logic [22:0] r_queued, n_queued;
    logic [31:0] r_daily, n_daily;

    logic [2:0]  r_res_code, n_res_code;
    logic [15:0] r_res_tag, n_res_tag;
    logic [15:0] r_res_cnt, n_res_cnt;
    logic [32:0] r_res_delay, n_res_delay;
    logic        r_res_thr, n_res_thr;

    logic [swrt_pkg::LOG_FW-1:0] r_app, n_app;
    logic [32:0] r_tdelay, n_tdelay;
    logic [31:0] r_ttmo, n_ttmo;
    logic [32:0] r_prod;

    swrt_pkg::t_qctl   w_qctl;
    swrt_pkg::t_logctl w_lctl;
    swrt_pkg::t_req    w_cdata [QD];
    logic              w_cvalid [QD];
    logic              w_cp [QD];
    swrt_pkg::t_req    w_tail;
    swrt_pkg::t_req    w_head;

    logic [swrt_pkg::LOG_FW-1:0] w_lfill;
    logic [31:0] w_lhead;

    logic        w_div_start, w_div_done;
    logic [22:0] w_quot;

    // queue chain
    for (genvar g = 0; g < QD; g++) begin : g_cell
        swrt_pkg::t_req w_ld, w_rd;
        logic w_lv, w_lp, w_rv;
        if (g == 0) begin : g_first
            assign w_ld = w_cdata[g];
            assign w_lv = 1'b1;
            assign w_lp = 1'b0;
        end else begin : g_mid
            assign w_ld = w_cdata[g-1];
            assign w_lv = w_cvalid[g-1];
            assign w_lp = w_cp[g-1];
        end
        if (g == QD - 1) begin : g_last
            assign w_rd = w_cdata[g];
            assign w_rv = 1'b0;
        end else begin : g_body
            assign w_rd = w_cdata[g+1];
            assign w_rv = w_cvalid[g+1];
        end
        swrt_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_qctl),
            .i_left_data  (w_ld),
            .i_left_valid (w_lv),
            .i_left_p     (w_lp),
            .i_right_data (w_rd),
            .i_right_valid(w_rv),
            .o_data       (w_cdata[g]),
            .o_valid      (w_cvalid[g]),
            .o_p          (w_cp[g])
        );
    end

    assign w_head = w_cdata[0];

    // tail is the last valid slot
    always_comb begin
        w_tail = '0;
        for (int k = 0; k < QD; k++) begin
            if (w_cvalid[k] && ((k == QD - 1) || !w_cvalid[(k + 1) % QD])) begin
                w_tail = w_tail | w_cdata[k];
            end
        end
    end

    swrt_log u_log (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_lctl),
        .o_fill     (w_lfill),
        .o_head_time(w_lhead)
    );

    logic [23:0] w_ahead;
    assign w_ahead = {1'b0, r_queued} - {8'b0, w_tail.count};

    swrt_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_dividend(w_ahead[22:0]),
        .i_divisor (r_rate),
        .o_done    (w_div_done),
        .o_quot    (w_quot)
    );

    // decision terms
    logic [32:0] w_hdelay, w_habs, w_edelay, w_tabs;
    logic        w_htout, w_dly_rej, w_send_ok, w_expire, w_ttout_now, w_ahead_pos;
    logic [32:0] w_dsum;
    logic [16:0] w_rsum;
    logic [22:0] w_q_sub;
    logic [34:0] w_fc, w_fcabs;

    assign w_hdelay  = {1'b0, r_item.time_ms} - {1'b0, w_head.time_ms};
    assign w_habs    = w_hdelay[32] ? (33'd0 - w_hdelay) : w_hdelay;
    assign w_htout   = (w_head.timeout != 32'd0) && (w_habs >= {1'b0, w_head.timeout});
    assign w_dsum    = {1'b0, r_daily} + {17'b0, w_head.count};
    assign w_dly_rej = (r_dlim != 32'd0) && (w_dsum > {1'b0, r_dlim});
    assign w_rsum    = {6'b0, w_lfill} + {1'b0, w_head.count};
    assign w_send_ok = (r_rate == 11'd0) || (w_rsum <= {6'b0, r_rate});
    assign w_edelay  = {1'b0, r_item.time_ms} - {1'b0, w_lhead};
    assign w_expire  = (w_lfill != '0) && ($signed(w_edelay) > $signed({17'b0, r_win}));
    assign w_tabs    = n_tdelay[32] ? (33'd0 - n_tdelay) : n_tdelay;
    assign w_ttout_now = (w_tail.timeout != 32'd0) && (w_tabs >= {1'b0, w_tail.timeout});
    assign w_ahead_pos = !w_ahead[23] && (w_ahead != 24'd0);
    assign w_fc      = {{2{r_tdelay[32]}}, r_tdelay} + {2'b0, r_prod};
    assign w_fcabs   = w_fc[34] ? (35'd0 - w_fc) : w_fc;

    always_comb begin
        n_tdelay = {1'b0, r_item.time_ms} - {1'b0, w_tail.time_ms};
    end

    logic [15:0] w_takecnt;
    always_comb begin
        w_takecnt = (r_state == swrt_pkg::S_FC) ? w_tail.count : w_head.count;
        w_q_sub = ({7'b0, w_takecnt} <= r_queued) ? (r_queued - {7'b0, w_takecnt}) : 23'd0;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            swrt_pkg::S_IDLE: begin
                if (i_in_valid) n_state = i_func ? swrt_pkg::S_POLL : swrt_pkg::S_PUSH;
            end
            swrt_pkg::S_PUSH: n_state = swrt_pkg::S_DONE;
            swrt_pkg::S_POLL: begin
                n_state = (r_fill == '0) ? swrt_pkg::S_DONE : swrt_pkg::S_EXP_RD;
            end
            swrt_pkg::S_EXP_RD: n_state = swrt_pkg::S_EXP_CHK;
            swrt_pkg::S_EXP_CHK: begin
                n_state = w_expire ? swrt_pkg::S_EXP_RD : swrt_pkg::S_DECIDE;
            end
            swrt_pkg::S_DECIDE: begin
                if (w_htout || w_dly_rej) begin
                    n_state = swrt_pkg::S_DONE;
                end else if (w_send_ok) begin
                    n_state = (w_head.count != 16'd0) ? swrt_pkg::S_APPEND : swrt_pkg::S_DONE;
                end else if (w_tail.timeout != 32'd0 && !w_ttout_now && w_ahead_pos) begin
                    n_state = swrt_pkg::S_DIV;
                end else begin
                    n_state = swrt_pkg::S_DONE;
                end
            end
            swrt_pkg::S_APPEND: begin
                if (r_app == swrt_pkg::LOG_FW'(1)) n_state = swrt_pkg::S_DONE;
            end
            swrt_pkg::S_DIV: if (w_div_done) n_state = swrt_pkg::S_MUL;
            swrt_pkg::S_MUL: n_state = swrt_pkg::S_FC;
            swrt_pkg::S_FC:  n_state = swrt_pkg::S_DONE;
            swrt_pkg::S_DONE: begin
                if (!o_out_valid || i_out_ready) n_state = swrt_pkg::S_IDLE;
            end
            default: n_state = swrt_pkg::S_IDLE;
        endcase
    end

    // datapath and control outputs
    always_comb begin
        w_qctl.op   = swrt_pkg::Q_HOLD;
        w_qctl.item = r_item;
        w_lctl.pop   = 1'b0;
        w_lctl.push  = 1'b0;
        w_lctl.wdata = r_item.time_ms;
        w_div_start  = 1'b0;
        n_fill      = r_fill;
        n_queued    = r_queued;
        n_daily     = r_daily;
        n_app       = r_app;
        n_ttmo      = r_ttmo;
        n_res_code  = r_res_code;
        n_res_tag   = r_res_tag;
        n_res_cnt   = r_res_cnt;
        n_res_delay = r_res_delay;
        n_res_thr   = r_res_thr;
        case (r_state)
            swrt_pkg::S_PUSH: begin
                n_res_tag   = r_item.tag;
                n_res_cnt   = r_item.count;
                n_res_delay = '0;
                n_res_thr   = 1'b0;
                if ((r_rate != 11'd0 && r_item.count > {5'b0, r_rate})
                        || r_fill >= swrt_pkg::Q_FW'(QD)) begin
                    n_res_code = swrt_pkg::CODE_REJECT;
                end else begin
                    w_qctl.op  = swrt_pkg::Q_INS;
                    n_fill     = r_fill + 1'b1;
                    n_queued   = r_queued + {7'b0, r_item.count};
                    n_res_code = swrt_pkg::CODE_QUEUED;
                end
            end
            swrt_pkg::S_POLL: begin
                n_res_code  = swrt_pkg::CODE_IDLE;
                n_res_tag   = '0;
                n_res_cnt   = '0;
                n_res_delay = '0;
                n_res_thr   = 1'b0;
            end
            swrt_pkg::S_EXP_CHK: begin
                w_lctl.pop = w_expire;
            end
            swrt_pkg::S_DECIDE: begin
                n_res_tag   = w_head.tag;
                n_res_cnt   = w_head.count;
                n_res_delay = '0;
                n_res_thr   = 1'b0;
                n_ttmo      = w_tail.timeout;
                if (w_htout || w_dly_rej || w_send_ok) begin
                    w_qctl.op = swrt_pkg::Q_POP;
                    n_fill    = r_fill - 1'b1;
                    n_queued  = w_q_sub;
                    if (w_htout) begin
                        n_res_code  = swrt_pkg::CODE_HEAD_TIMEOUT;
                        n_res_delay = w_hdelay;
                    end else if (w_dly_rej) begin
                        n_res_code = swrt_pkg::CODE_DAILY;
                    end else begin
                        n_res_code = swrt_pkg::CODE_SENT;
                        n_daily    = w_dsum[32] ? 32'hFFFF_FFFF : w_dsum[31:0];
                        n_app      = (w_head.count >= 16'(swrt_pkg::LOG_DEPTH))
                                   ? swrt_pkg::LOG_FW'(swrt_pkg::LOG_DEPTH)
                                   : swrt_pkg::LOG_FW'(w_head.count);
                    end
                end else begin
                    n_res_thr  = 1'b1;
                    n_res_code = swrt_pkg::CODE_THROTTLED;
                    if (w_ttout_now) begin
                        w_qctl.op   = swrt_pkg::Q_DROP;
                        n_fill      = r_fill - 1'b1;
                        n_queued    = ({7'b0, w_tail.count} <= r_queued)
                                    ? (r_queued - {7'b0, w_tail.count}) : 23'd0;
                        n_res_code  = swrt_pkg::CODE_TAIL_TIMEOUT;
                        n_res_tag   = w_tail.tag;
                        n_res_cnt   = w_tail.count;
                        n_res_delay = n_tdelay;
                    end else if (w_tail.timeout != 32'd0 && w_ahead_pos) begin
                        w_div_start = 1'b1;
                    end
                end
            end
            swrt_pkg::S_APPEND: begin
                w_lctl.push = 1'b1;
                n_app       = r_app - 1'b1;
            end
            swrt_pkg::S_FC: begin
                if (w_fcabs >= {3'b0, r_ttmo}) begin
                    w_qctl.op   = swrt_pkg::Q_DROP;
                    n_fill      = r_fill - 1'b1;
                    n_queued    = w_q_sub;
                    n_res_code  = swrt_pkg::CODE_TAIL_TIMEOUT;
                    n_res_tag   = w_tail.tag;
                    n_res_cnt   = w_tail.count;
                    n_res_delay = r_tdelay;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_in_ready = (r_state == swrt_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.tag     <= i_msg_tag;
            r_item.count   <= i_cmd_count;
            r_item.key     <= i_sort_key;
            r_item.time_ms <= i_time_ms;
            r_item.timeout <= i_is_withdraw ? 32'd0 : i_timeout_ms;
        end
        r_app       <= n_app;
        r_ttmo      <= n_ttmo;
        r_res_code  <= n_res_code;
        r_res_tag   <= n_res_tag;
        r_res_cnt   <= n_res_cnt;
        r_res_delay <= n_res_delay;
        r_res_thr   <= n_res_thr;
        if (r_state == swrt_pkg::S_DECIDE) r_tdelay <= n_tdelay;
        r_prod <= 33'(w_quot) * 33'(swrt_pkg::MS_PER_SECOND);
        if (r_state == swrt_pkg::S_DONE && (!o_out_valid || i_out_ready)) begin
            o_code         <= r_res_code;
            o_out_tag      <= r_res_tag;
            o_out_count    <= r_res_cnt;
            o_delay_ms     <= r_res_delay;
            o_daily_total  <= r_daily;
            o_queued_total <= r_queued;
            o_throttled    <= r_res_thr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= swrt_pkg::S_IDLE;
            r_fill      <= '0;
            r_queued    <= '0;
            r_daily     <= '0;
            r_rate      <= '0;
            r_dlim      <= '0;
            r_win       <= 16'd1500;
            o_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_queued <= n_queued;
            // a start total write reloads the daily count
            if (i_cfg_we && i_cfg_idx == swrt_pkg::CFG_START_DAILY) begin
                r_daily <= i_cfg_data;
            end else begin
                r_daily <= n_daily;
            end
            if (r_state == swrt_pkg::S_DONE && (!o_out_valid || i_out_ready)) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    swrt_pkg::CFG_RATE_LIMIT:  r_rate <= i_cfg_data[10:0];
                    swrt_pkg::CFG_DAILY_LIMIT: r_dlim <= i_cfg_data;
                    swrt_pkg::CFG_WINDOW_MS:   r_win  <= i_cfg_data[15:0];
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule
